@@ sv/hsv2rgb_pkg.sv @@
// ============================================================================
// HSV to RGB conversion package
// Default widths and the hue sector codes shared by the pipeline stages.
// ============================================================================
package hsv2rgb_pkg;

    // Default width of saturation, value, alpha and the color channels.
    localparam int COMPONENT_BITS_DEF = 8;

    // Default width of the hue fraction of a turn.
    localparam int HUE_BITS_DEF = 16;

    // Sixth of the color wheel that a hue falls in.
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW     = 3'd0,
        SECTOR_YELLOW_GREEN   = 3'd1,
        SECTOR_GREEN_CYAN     = 3'd2,
        SECTOR_CYAN_BLUE      = 3'd3,
        SECTOR_BLUE_MAGENTA   = 3'd4,
        SECTOR_MAGENTA_RED    = 3'd5
    } sector_t;

endpackage

@@ sv/hsv2rgb_front.sv @@
// ============================================================================
// HSV to RGB front stage
// Splits hue into a sector and fraction, and forms v*s and v*M.
// ============================================================================
module hsv2rgb_front #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_BITS       = hsv2rgb_pkg::HUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [HUE_BITS-1:0]           hue,
    input  logic [COMPONENT_BITS-1:0]     saturation,
    input  logic [COMPONENT_BITS-1:0]     brightness,
    input  logic [COMPONENT_BITS-1:0]     alpha_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsv2rgb_pkg::sector_t          sector,
    output logic [HUE_BITS-1:0]           frac,
    output logic [2*COMPONENT_BITS-1:0]   vs,
    output logic [2*COMPONENT_BITS-1:0]   vm,
    output logic [COMPONENT_BITS-1:0]     alpha
);
    import hsv2rgb_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam int H = HUE_BITS;

    logic              valid_reg;
    sector_t           sector_reg;
    sector_t           sector_next;
    logic [H-1:0]      frac_reg;
    logic [H-1:0]      frac_next;
    logic [2*C-1:0]    vs_reg;
    logic [2*C-1:0]    vs_next;
    logic [2*C-1:0]    vm_reg;
    logic [2*C-1:0]    vm_next;
    logic [C-1:0]      alpha_reg;
    logic [H+2:0]      hue6;

    // The stage takes a new transfer when it is empty or its content moves on.
    assign in_ready = !valid_reg || out_ready;

    // Hue times six by shift and add; the top bits are the sector.
    always_comb begin
        hue6        = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        sector_next = sector_t'(hue6[H+2:H]);
        frac_next   = hue6[H-1:0];
        vs_next     = {{C{1'b0}}, brightness} * {{C{1'b0}}, saturation};
        vm_next     = {brightness, {C{1'b0}}} - {{C{1'b0}}, brightness};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_next;
            frac_reg   <= frac_next;
            vs_reg     <= vs_next;
            vm_reg     <= vm_next;
            alpha_reg  <= alpha_in;
        end
    end

    assign out_valid = valid_reg;
    assign sector    = sector_reg;
    assign frac      = frac_reg;
    assign vs        = vs_reg;
    assign vm        = vm_reg;
    assign alpha     = alpha_reg;

endmodule

@@ sv/hsv2rgb_mult.sv @@
// ============================================================================
// HSV to RGB multiply stage
// Multiplies v*s by the hue fraction to give v*s*f.
// ============================================================================
module hsv2rgb_mult #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_BITS       = hsv2rgb_pkg::HUE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  hsv2rgb_pkg::sector_t                   sector_in,
    input  logic [HUE_BITS-1:0]                    frac,
    input  logic [2*COMPONENT_BITS-1:0]            vs_in,
    input  logic [2*COMPONENT_BITS-1:0]            vm_in,
    input  logic [COMPONENT_BITS-1:0]              alpha_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hsv2rgb_pkg::sector_t                   sector_out,
    output logic [2*COMPONENT_BITS+HUE_BITS-1:0]   vsf,
    output logic [2*COMPONENT_BITS-1:0]            vs_out,
    output logic [2*COMPONENT_BITS-1:0]            vm_out,
    output logic [COMPONENT_BITS-1:0]              alpha_out
);
    import hsv2rgb_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam int H = HUE_BITS;

    logic                valid_reg;
    sector_t             sector_reg;
    logic [2*C+H-1:0]    vsf_reg;
    logic [2*C+H-1:0]    vsf_next;
    logic [2*C-1:0]      vs_reg;
    logic [2*C-1:0]      vm_reg;
    logic [C-1:0]        alpha_reg;

    assign in_ready = !valid_reg || out_ready;

    // The widest product of the pipeline.
    assign vsf_next = {{H{1'b0}}, vs_in} * {{(2*C){1'b0}}, frac};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_in;
            vsf_reg    <= vsf_next;
            vs_reg     <= vs_in;
            vm_reg     <= vm_in;
            alpha_reg  <= alpha_in;
        end
    end

    assign out_valid  = valid_reg;
    assign sector_out = sector_reg;
    assign vsf        = vsf_reg;
    assign vs_out     = vs_reg;
    assign vm_out     = vm_reg;
    assign alpha_out  = alpha_reg;

endmodule

@@ sv/hsv2rgb_level.sv @@
// ============================================================================
// HSV to RGB level stage
// Forms the p, q and t numerators and scales them by the hue range with
// rounding, leaving only the division by the component maximum.
// ============================================================================
module hsv2rgb_level #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_BITS       = hsv2rgb_pkg::HUE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  hsv2rgb_pkg::sector_t                   sector_in,
    input  logic [2*COMPONENT_BITS+HUE_BITS-1:0]   vsf,
    input  logic [2*COMPONENT_BITS-1:0]            vs,
    input  logic [2*COMPONENT_BITS-1:0]            vm,
    input  logic [COMPONENT_BITS-1:0]              alpha_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hsv2rgb_pkg::sector_t                   sector_out,
    output logic [2*COMPONENT_BITS-1:0]            yp,
    output logic [2*COMPONENT_BITS-1:0]            yq,
    output logic [2*COMPONENT_BITS-1:0]            yt,
    output logic [COMPONENT_BITS-1:0]              alpha_out
);
    import hsv2rgb_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam int H = HUE_BITS;
    localparam logic [C-1:0]     COMP_MAX = '1;
    // Half of M*F, added so that the later truncations round to nearest.
    localparam logic [2*C+H:0]   ROUND_BIAS = {{(C+H+1){1'b0}}, COMP_MAX} << (H-1);

    logic              valid_reg;
    sector_t           sector_reg;
    logic [2*C-1:0]    yp_reg;
    logic [2*C-1:0]    yp_next;
    logic [2*C-1:0]    yq_reg;
    logic [2*C-1:0]    yq_next;
    logic [2*C-1:0]    yt_reg;
    logic [2*C-1:0]    yt_next;
    logic [C-1:0]      alpha_reg;
    logic [2*C+H:0]    vmf;
    logic [2*C+H:0]    vsf_full;
    logic [2*C+H:0]    vsf_ext;
    logic [2*C+H:0]    p_sum;
    logic [2*C+H:0]    q_sum;
    logic [2*C+H:0]    t_sum;

    assign in_ready = !valid_reg || out_ready;

    // p = v*M*F - v*s*F, q = v*M*F - v*s*f, t = v*M*F - v*s*(F-f).
    // The sums never go negative because s is at most M and f below F.
    always_comb begin
        vmf      = {1'b0, vm, {H{1'b0}}};
        vsf_full = {1'b0, vs, {H{1'b0}}};
        vsf_ext  = {1'b0, vsf};
        p_sum    = vmf - vsf_full + ROUND_BIAS;
        q_sum    = vmf - vsf_ext + ROUND_BIAS;
        t_sum    = vmf - vsf_full + vsf_ext + ROUND_BIAS;
        yp_next  = p_sum[2*C+H-1:H];
        yq_next  = q_sum[2*C+H-1:H];
        yt_next  = t_sum[2*C+H-1:H];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sector_reg <= sector_in;
            yp_reg     <= yp_next;
            yq_reg     <= yq_next;
            yt_reg     <= yt_next;
            alpha_reg  <= alpha_in;
        end
    end

    assign out_valid  = valid_reg;
    assign sector_out = sector_reg;
    assign yp         = yp_reg;
    assign yq         = yq_reg;
    assign yt         = yt_reg;
    assign alpha_out  = alpha_reg;

endmodule

@@ sv/hsv2rgb_place.sv @@
// ============================================================================
// HSV to RGB placement stage
// Divides the scaled levels by the component maximum and places v, p, q
// and t on the red, green and blue outputs by sector.
// ============================================================================
module hsv2rgb_place #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsv2rgb_pkg::sector_t          sector,
    input  logic [2*COMPONENT_BITS-1:0]   yp,
    input  logic [2*COMPONENT_BITS-1:0]   yq,
    input  logic [2*COMPONENT_BITS-1:0]   yt,
    input  logic [COMPONENT_BITS-1:0]     alpha_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COMPONENT_BITS-1:0]     red,
    output logic [COMPONENT_BITS-1:0]     green,
    output logic [COMPONENT_BITS-1:0]     blue,
    output logic [COMPONENT_BITS-1:0]     alpha_out
);
    import hsv2rgb_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam logic [C-1:0] COMP_MAX = '1;

    logic            valid_reg;
    logic [C-1:0]    red_reg;
    logic [C-1:0]    red_next;
    logic [C-1:0]    green_reg;
    logic [C-1:0]    green_next;
    logic [C-1:0]    blue_reg;
    logic [C-1:0]    blue_next;
    logic [C-1:0]    alpha_reg;
    logic [C-1:0]    lvl_v;
    logic [C-1:0]    lvl_p;
    logic [C-1:0]    lvl_q;
    logic [C-1:0]    lvl_t;

    // Division by 2^C-1: y = hi*2^C + lo = hi*M + (hi + lo), and hi + lo
    // is at most 2M, so the quotient is hi plus a correction of 0, 1 or 2.
    function automatic logic [C-1:0] div_by_max(input logic [2*C-1:0] y);
        logic [C-1:0] hi;
        logic [C:0]   fold;
        logic [1:0]   corr;
        hi   = y[2*C-1:C];
        fold = {1'b0, hi} + {1'b0, y[C-1:0]};
        if (fold >= {COMP_MAX, 1'b0}) begin
            corr = 2'd2;
        end else if (fold >= {1'b0, COMP_MAX}) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        return hi + {{(C-2){1'b0}}, corr};
    endfunction

    // In q + t - p the s terms cancel, leaving v*M plus a rounding offset
    // of at most M/2 + 1, so its division by M gives exactly v.
    function automatic logic [C-1:0] lvl_v_from(input logic [2*C-1:0] sp,
                                                input logic [2*C-1:0] sq,
                                                input logic [2*C-1:0] st);
        logic [2*C+1:0] sum;
        sum = {2'b00, sq} + {2'b00, st} - {2'b00, sp};
        return div_by_max(sum[2*C-1:0]);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    // Final levels; the value level is recovered from the other three.
    always_comb begin
        lvl_p = div_by_max(yp);
        lvl_q = div_by_max(yq);
        lvl_t = div_by_max(yt);
        lvl_v = lvl_v_from(yp, yq, yt);
    end

    // Sector placement of v, t, p and q onto the three channels.
    always_comb begin
        case (sector)
            SECTOR_RED_YELLOW: begin
                red_next = lvl_v; green_next = lvl_t; blue_next = lvl_p;
            end
            SECTOR_YELLOW_GREEN: begin
                red_next = lvl_q; green_next = lvl_v; blue_next = lvl_p;
            end
            SECTOR_GREEN_CYAN: begin
                red_next = lvl_p; green_next = lvl_v; blue_next = lvl_t;
            end
            SECTOR_CYAN_BLUE: begin
                red_next = lvl_p; green_next = lvl_q; blue_next = lvl_v;
            end
            SECTOR_BLUE_MAGENTA: begin
                red_next = lvl_t; green_next = lvl_p; blue_next = lvl_v;
            end
            default: begin
                red_next = lvl_v; green_next = lvl_p; blue_next = lvl_q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_in;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

@@ sv/hsv_to_rgb_convert_top.sv @@
// ============================================================================
// HSV to RGB conversion, top level
// Channel   Direction  Handshake          Payload
// s_        input      s_valid / s_ready  s_hue, s_saturation, s_brightness,
//                                         s_alpha_in
// m_        output     m_valid / m_ready  m_red, m_green, m_blue, m_alpha_out
//
// One pixel is accepted every clock cycle while nothing stalls; a pixel
// reaches m_ after passing through four register stages (sector
// split, v*s*f multiply, level scaling, and division with sector placement).
// The v*s*f multiply sets the depth of the stage that holds it.
// A stall on m_ready fills the empty stages first and then holds s_ready low.
// Reset clears the stage valid bits only.
// ============================================================================
module hsv_to_rgb_convert_top #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_BITS       = hsv2rgb_pkg::HUE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [HUE_BITS-1:0]         s_hue,
    input  logic [COMPONENT_BITS-1:0]   s_saturation,
    input  logic [COMPONENT_BITS-1:0]   s_brightness,
    input  logic [COMPONENT_BITS-1:0]   s_alpha_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COMPONENT_BITS-1:0]   m_red,
    output logic [COMPONENT_BITS-1:0]   m_green,
    output logic [COMPONENT_BITS-1:0]   m_blue,
    output logic [COMPONENT_BITS-1:0]   m_alpha_out
);
    import hsv2rgb_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam int H = HUE_BITS;

    // Stage one to two.
    logic              fr_valid;
    logic              fr_ready;
    sector_t           fr_sector;
    logic [H-1:0]      fr_frac;
    logic [2*C-1:0]    fr_vs;
    logic [2*C-1:0]    fr_vm;
    logic [C-1:0]      fr_alpha;

    // Stage two to three.
    logic              mu_valid;
    logic              mu_ready;
    sector_t           mu_sector;
    logic [2*C+H-1:0]  mu_vsf;
    logic [2*C-1:0]    mu_vs;
    logic [2*C-1:0]    mu_vm;
    logic [C-1:0]      mu_alpha;

    // Stage three to four.
    logic              lv_valid;
    logic              lv_ready;
    sector_t           lv_sector;
    logic [2*C-1:0]    lv_yp;
    logic [2*C-1:0]    lv_yq;
    logic [2*C-1:0]    lv_yt;
    logic [C-1:0]      lv_alpha;

    hsv2rgb_front #(
        .COMPONENT_BITS (C),
        .HUE_BITS       (H)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .hue        (s_hue),
        .saturation (s_saturation),
        .brightness (s_brightness),
        .alpha_in   (s_alpha_in),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .sector     (fr_sector),
        .frac       (fr_frac),
        .vs         (fr_vs),
        .vm         (fr_vm),
        .alpha      (fr_alpha)
    );

    hsv2rgb_mult #(
        .COMPONENT_BITS (C),
        .HUE_BITS       (H)
    ) u_mult (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .sector_in  (fr_sector),
        .frac       (fr_frac),
        .vs_in      (fr_vs),
        .vm_in      (fr_vm),
        .alpha_in   (fr_alpha),
        .out_valid  (mu_valid),
        .out_ready  (mu_ready),
        .sector_out (mu_sector),
        .vsf        (mu_vsf),
        .vs_out     (mu_vs),
        .vm_out     (mu_vm),
        .alpha_out  (mu_alpha)
    );

    hsv2rgb_level #(
        .COMPONENT_BITS (C),
        .HUE_BITS       (H)
    ) u_level (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (mu_valid),
        .in_ready   (mu_ready),
        .sector_in  (mu_sector),
        .vsf        (mu_vsf),
        .vs         (mu_vs),
        .vm         (mu_vm),
        .alpha_in   (mu_alpha),
        .out_valid  (lv_valid),
        .out_ready  (lv_ready),
        .sector_out (lv_sector),
        .yp         (lv_yp),
        .yq         (lv_yq),
        .yt         (lv_yt),
        .alpha_out  (lv_alpha)
    );

    hsv2rgb_place #(
        .COMPONENT_BITS (C)
    ) u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lv_valid),
        .in_ready  (lv_ready),
        .sector    (lv_sector),
        .yp        (lv_yp),
        .yq        (lv_yq),
        .yt        (lv_yt),
        .alpha_in  (lv_alpha),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue),
        .alpha_out (m_alpha_out)
    );

endmodule

@@ sv/hsv2rgb_chk.sv @@
// ============================================================================
// HSV to RGB port checker
// Watches the top-level ports for output holding, input blocking,
// pass-through of alpha and gray pixels, and pipeline latency.
// ============================================================================
module hsv2rgb_chk #(
    parameter int COMPONENT_BITS = hsv2rgb_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_BITS       = hsv2rgb_pkg::HUE_BITS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [COMPONENT_BITS-1:0]   s_saturation,
    input logic [COMPONENT_BITS-1:0]   s_brightness,
    input logic [COMPONENT_BITS-1:0]   s_alpha_in,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [COMPONENT_BITS-1:0]   m_red,
    input logic [COMPONENT_BITS-1:0]   m_green,
    input logic [COMPONENT_BITS-1:0]   m_blue,
    input logic [COMPONENT_BITS-1:0]   m_alpha_out
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its pixel.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_alpha_out))
        else $error("result changed while stalled");

    // With the output side taking transfers, the pipeline never blocks input.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output is drained");

    // Alpha arrives unchanged at the output when nothing stalls.
    a_alpha_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid && (m_alpha_out == $past(s_alpha_in, 4)))
        else $error("alpha not passed through");

    // Zero saturation gives the value on every channel.
    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_saturation == '0)) ##1 m_ready ##1 m_ready
        ##1 m_ready
        |=> m_valid && (m_red == $past(s_brightness, 4))
            && (m_green == $past(s_brightness, 4))
            && (m_blue == $past(s_brightness, 4)))
        else $error("gray pixel not reproduced");

endmodule

bind hsv_to_rgb_convert_top hsv2rgb_chk #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .HUE_BITS       (HUE_BITS)
) u_hsv2rgb_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_saturation (s_saturation),
    .s_brightness (s_brightness),
    .s_alpha_in   (s_alpha_in),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_red        (m_red),
    .m_green      (m_green),
    .m_blue       (m_blue),
    .m_alpha_out  (m_alpha_out)
);
